FILE: rtl/deq_pkg.sv
// Shared types, sizes and helpers for the double-ended queue core.
// Depends on nothing; imported by double_ended_queue_core.
package deq_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int MODE_W = 3;
	localparam int VAL_W  = 32;
	localparam int OUT_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_POP_BACK   = 3'd1,
		MODE_PUSH_FRONT = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_LIST       = 3'd4
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_LIST
	} state_t;

	// (base + off) mod DEPTH; base < DEPTH and off <= DEPTH
	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// stored word, sign extended (or truncated) to the result width
	function automatic logic signed [OUT_W-1:0] word_ext(input logic [WORD_BITS-1:0] w);
		logic signed [WORD_BITS-1:0] sw;
		sw = $signed(w);
		return OUT_W'(sw);
	endfunction

endpackage

FILE: rtl/double_ended_queue_core.sv
// Double-ended queue core: ring buffer in one synchronous memory plus control.
// Depends on deq_pkg (sizes, mode/status codes, wrap and sign-extend helpers).
//
// Bounded deque of DEPTH words kept in a ring buffer (front pointer + count).
// A request is taken when start is high and busy is low. Every request gives
// one result, except a listing of a nonempty store, which gives one result per
// stored word from front to back with last set on the final one. Results show
// on word/status/occupancy/last for exactly one cycle, marked by strobe; the
// receiver cannot stall them, so it must take each one as it appears. Pushes,
// rejected requests (full push, empty pop or list) and unknown modes leave
// busy low, so the next request may follow in the very next cycle; the
// result appears the cycle after the request. A pop raises busy while its
// word is read through the registered read port of the slot memory. A
// listing keeps busy high until its final word and emits one word per cycle,
// since the memory has a single read port. Pushes into a full store are dropped
// with status full; pops and listings on an empty store return status empty.
// The slot memory has no reset and needs no clearing pass: only slots that
// hold a stored word are ever read.
module double_ended_queue_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [deq_pkg::MODE_W-1:0]            mode,
	input  logic signed [deq_pkg::VAL_W-1:0]      value,
	output logic                                  strobe,
	output logic signed [deq_pkg::OUT_W-1:0]      word,
	output logic [deq_pkg::STAT_W-1:0]            status,
	output logic [deq_pkg::OCC_W-1:0]             occupancy,
	output logic                                  last
);
	import deq_pkg::*;

	// slot memory: one write and one registered read port
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	// control state
	state_t           state_q, state_d;
	logic [PTR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [PTR_W-1:0] idx_q, idx_d;     // listing position being emitted

	// result register
	logic                    strobe_q;
	logic signed [OUT_W-1:0] word_q;
	status_t                 status_q;
	logic [OCC_W-1:0]        occ_q;
	logic                    last_q;

	// combinational controls
	logic                    acc;
	logic                    full, empty, list_end;
	logic                    wr_en, rd_en;
	logic [PTR_W-1:0]        wr_addr, rd_addr;
	logic                    out_ld;
	logic signed [OUT_W-1:0] out_word_d;
	status_t                 out_status_d;
	logic                    out_last_d;

	assign busy     = (state_q != ST_IDLE);
	assign acc      = start && !busy;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign list_end = (CNT_W'(idx_q) == count_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			strobe_q <= out_ld;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_ld) begin
			word_q   <= out_word_d;
			status_q <= out_status_d;
			occ_q    <= OCC_W'(count_d);
			last_q   <= out_last_d;
		end
	end

	// Writes only happen on an accepted push in idle; reads happen on an
	// accepted pop/list or while listing. They never share an edge, and a
	// read at a later edge sees any earlier write, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= WORD_BITS'($unsigned(value));
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		count_d      = count_q;
		idx_d        = idx_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		out_ld       = 1'b0;
		out_word_d   = '0;
		out_status_d = STAT_OK;
		out_last_d   = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (mode)
						MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
							out_ld = 1'b1;
							if (full) begin
								out_status_d = STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (mode == MODE_PUSH_BACK) begin
									wr_addr = wrap_add(front_q, count_q);
								end else begin
									// step front back by one, wrapping
									front_d = wrap_add(front_q, CNT_W'(DEPTH - 1));
									wr_addr = front_d;
								end
							end
						end
						MODE_POP_BACK, MODE_POP_FRONT: begin
							if (empty) begin
								out_ld       = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								count_d = count_q - CNT_W'(1);
								state_d = ST_POP;
								if (mode == MODE_POP_BACK) begin
									rd_addr = wrap_add(front_q, count_q - CNT_W'(1));
								end else begin
									rd_addr = front_q;
									front_d = wrap_add(front_q, CNT_W'(1));
								end
							end
						end
						MODE_LIST: begin
							if (empty) begin
								out_ld       = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = front_q;
								idx_d   = '0;
								state_d = ST_LIST;
							end
						end
						default: begin
							out_ld = 1'b1;
						end
					endcase
				end
			end
			ST_POP: begin
				// popped word is in the read register now
				out_ld     = 1'b1;
				out_word_d = word_ext(rd_data_q);
				state_d    = ST_IDLE;
			end
			ST_LIST: begin
				out_ld     = 1'b1;
				out_word_d = word_ext(rd_data_q);
				out_last_d = list_end;
				if (list_end) begin
					state_d = ST_IDLE;
				end else begin
					// fetch the next word while this one goes out
					rd_en   = 1'b1;
					rd_addr = wrap_add(front_q, CNT_W'(idx_q) + CNT_W'(1));
					idx_d   = idx_q + PTR_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign strobe    = strobe_q;
	assign word      = word_q;
	assign status    = status_q;
	assign occupancy = occ_q;
	assign last      = last_q;

	// a pop on a nonempty store yields its result via ST_POP and the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && !empty && (mode == MODE_POP_BACK || mode == MODE_POP_FRONT)
		|-> ##2 strobe)
		else $error("pop result did not appear two cycles after request");

	// an accepted push into a non-full store grows the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		acc && !full && (mode == MODE_PUSH_BACK || mode == MODE_PUSH_FRONT)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not advance the count");

	// memory is written only from idle, never during a pop or listing
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE && !rd_en)
		else $error("slot write overlaps a read sequence");

	// the final word of a listing returns control to idle with last set
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST && list_end |=> state_q == ST_IDLE && strobe && last)
		else $error("listing did not end cleanly");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for double_ended_queue_core: directed and random requests
// with a cycle-accurate-in-content deque predictor and an in-order result checker.
// Depends on deq_pkg (sizes, mode and status codes) and the core RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	// watchdog: far above the slowest legal run (~150 requests, each up to
	// a 16-word listing plus a sender gap)
	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_REPORTS = 40;
	localparam logic [MODE_W-1:0] MODE_TOP = {MODE_W{1'b1}};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [MODE_W-1:0]        mode = '0;
	logic signed [VAL_W-1:0]  value = '0;
	logic                     strobe;
	logic signed [OUT_W-1:0]  word;
	logic [STAT_W-1:0]        status;
	logic [OCC_W-1:0]         occupancy;
	logic                     last;

	// one result as the core should present it
	typedef struct {
		logic signed [OUT_W-1:0] word;
		logic [STAT_W-1:0]       status;
		logic [OCC_W-1:0]        occupancy;
		logic                    last;
	} deq_result_t;

	deq_result_t due_results[$];

	// predictor state: ring contents, front position, stored word count
	logic signed [WORD_BITS-1:0] ring[DEPTH];
	int head = 0;
	int fill = 0;

	int mismatches = 0;
	int cycle_count = 0;
	int idle_pct = 0;

	double_ended_queue_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.value     (value),
		.strobe    (strobe),
		.word      (word),
		.status    (status),
		.occupancy (occupancy),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: timeout with %0d results still due", due_results.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
		end
	endtask

	function automatic void queue_result(input logic signed [OUT_W-1:0] w,
			input logic [STAT_W-1:0] st, input logic lst);
		deq_result_t r;
		r.word = w;
		r.status = st;
		r.occupancy = OCC_W'(fill);
		r.last = lst;
		due_results.push_back(r);
	endfunction

	// Apply one accepted request to the predicted deque and queue what it
	// must produce. Occupancy is taken after the update.
	function automatic void apply_deque_op(input logic [MODE_W-1:0] op,
			input logic signed [VAL_W-1:0] din);
		int slot;
		case (op)
			MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					// full: push dropped, nothing moves
					queue_result('0, STAT_FULL, 1'b1);
				end else begin
					if (op == MODE_PUSH_BACK) begin
						slot = (head + fill) % DEPTH;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						slot = head;
					end
					ring[slot] = din[WORD_BITS-1:0];
					fill++;
					queue_result('0, STAT_OK, 1'b1);
				end
			end
			MODE_POP_BACK, MODE_POP_FRONT: begin
				if (fill == 0) begin
					queue_result('0, STAT_EMPTY, 1'b1);
				end else begin
					if (op == MODE_POP_BACK) begin
						slot = (head + fill - 1) % DEPTH;
					end else begin
						slot = head;
						head = (head + 1) % DEPTH;
					end
					fill--;
					queue_result(OUT_W'(ring[slot]), STAT_OK, 1'b1);
				end
			end
			MODE_LIST: begin
				if (fill == 0) begin
					queue_result('0, STAT_EMPTY, 1'b1);
				end else begin
					// one result per stored word, front to back
					for (int i = 0; i < fill; i++) begin
						queue_result(OUT_W'(ring[(head + i) % DEPTH]), STAT_OK,
							i == fill - 1);
					end
				end
			end
			default: begin
				// unused mode codes: no state change, one plain result
				queue_result('0, STAT_OK, 1'b1);
			end
		endcase
	endfunction

	// Result checker: strobe marks a result for exactly one cycle, so every
	// sampled strobe must match the oldest predicted result.
	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (due_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result word=%0d status=%0d",
					word, status));
			end else begin
				want = due_results.pop_front();
				if (word !== want.word)
					flag_mismatch($sformatf("word %0d, want %0d", word, want.word));
				if (status !== want.status)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (occupancy !== want.occupancy)
					flag_mismatch($sformatf("occupancy %0d, want %0d",
						occupancy, want.occupancy));
				if (last !== want.last)
					flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	// Present one request and hold it until the core takes it. start stays
	// high afterwards unless the sender decides to idle, so back-to-back
	// requests never drop start in between.
	task automatic send_request(input logic [MODE_W-1:0] op,
			input logic signed [VAL_W-1:0] din);
		start <= 1'b1;
		mode  <= op;
		value <= din;
		do @(posedge clk); while (busy !== 1'b0);
		apply_deque_op(op, din);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Sender holds off until every predicted result has been seen.
	task automatic pause_until_drained();
		start <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// values: mostly random, sometimes the signed extremes and sign patterns
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return {1'b0, {(VAL_W-1){1'b1}}};
			1: return {1'b1, {(VAL_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// pops and listing on an empty store must be flagged empty
	task automatic test_empty_store();
		send_request(MODE_POP_BACK, 32'sd0);
		send_request(MODE_POP_FRONT, pick_value());
		send_request(MODE_LIST, pick_value());
	endtask

	task automatic test_unused_modes();
		for (int m = MODE_LIST + 1; m <= MODE_TOP; m++) begin
			send_request(MODE_W'(m), pick_value());
		end
	endtask

	// extreme values at both ends; the front push from position zero wraps
	task automatic test_extremes();
		send_request(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
		send_request(MODE_PUSH_FRONT, 32'sh8000_0000);
		send_request(MODE_PUSH_BACK, 32'sh0000_0000);
		send_request(MODE_PUSH_FRONT, 32'shFFFF_FFFF);
		send_request(MODE_PUSH_BACK, 32'sh5555_AAAA);
		send_request(MODE_PUSH_FRONT, 32'shAAAA_5555);
		send_request(MODE_LIST, '0);
		send_request(MODE_POP_FRONT, '0);
		send_request(MODE_POP_BACK, '0);
	endtask

	// fill to the top, try both pushes when full, list all sixteen
	task automatic test_full_store();
		while (fill < DEPTH) begin
			send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
				pick_value());
		end
		send_request(MODE_PUSH_BACK, pick_value());
		send_request(MODE_PUSH_FRONT, pick_value());
		send_request(MODE_LIST, '0);
		send_request(MODE_POP_BACK, '0);
		send_request(MODE_POP_FRONT, '0);
	endtask

	// Random mix in bursts that lean toward filling or draining, so the
	// store swings between empty and full and the ring wraps both ways.
	task automatic test_random_mix(input int requests);
		int push_pct;
		int burst_left;
		int roll;
		push_pct = 50;
		burst_left = 0;
		for (int n = 0; n < requests; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(4, 14);
				case ($urandom_range(2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 15;
				endcase
			end
			burst_left--;
			roll = $urandom_range(99);
			if (roll < 4)
				send_request(MODE_W'($urandom_range(MODE_LIST + 1, MODE_TOP)),
					pick_value());
			else if (roll < 14)
				send_request(MODE_LIST, pick_value());
			else if ($urandom_range(99) < push_pct)
				send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
					pick_value());
			else
				send_request($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT,
					pick_value());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, light sender gaps
		idle_pct = 11;
		test_empty_store();
		test_unused_modes();
		test_extremes();
		test_full_store();

		// random part: sender idles rarely, then often, then never
		idle_pct = 11;
		test_random_mix(40);
		pause_until_drained();
		idle_pct = 51;
		test_random_mix(40);
		idle_pct = 0;
		test_random_mix(40);

		// let the last results arrive, then a few quiet cycles
		pause_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
